// ===== rtl/blpm_pkg.sv =====
package blpm_pkg;

  // Field and register widths.
  localparam int SAMPLE_W   = 16;
  localparam int POS_W      = 12;
  localparam int LEN_W      = 12;
  localparam int LW_W       = 13;
  localparam int LEVEL_W    = 16;
  localparam int PSNR_W     = 16;
  localparam int FUSED_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Window accumulator widths.
  localparam int CNT_W = 13;
  localparam int SUM_W = 28;
  localparam int SQ_W  = 44;

  // Frame accumulator of Q8.8 field results; two fields of just under 256 dB each.
  localparam int ACC_W = 18;

  // Parameter defaults.
  localparam int DEF_MAX_LINE_WIDTH = 4096;
  localparam int DEF_SAMPLE_WIDTH   = 16;

  // Register reset values.
  localparam logic [LEN_W-1:0]          RST_WINDOW_START  = 12'd212;
  localparam logic [LEN_W-1:0]          RST_WINDOW_LENGTH = 12'd887;
  localparam logic [LW_W-1:0]           RST_LINE_WIDTH    = 13'd1135;
  localparam logic signed [LEVEL_W-1:0] RST_BLACK_LEVEL   = 16'sd256;
  localparam logic signed [LEVEL_W-1:0] RST_WHITE_LEVEL   = 16'sd844;

  // Arithmetic constants.
  localparam logic signed [ACC_W-1:0] CAP_Q8 = 18'sd20480;
  localparam logic [31:0] DB_PER_LOG2_Q16 = 32'd197283;
  // 10^10 = 2 * 2^32 + TEN_POW10_LO.
  localparam logic [31:0] TEN_POW10_LO = 32'd1410065408;
  localparam int TEN_POW10_HI_SHIFT = 33;
  // Below this noise power the capped test is meaningful at all.
  localparam int CAP_D_BITS = 23;
  localparam logic [5:0] LOG_INT_MAX = 6'd63;
  localparam logic [3:0] SQ_LAST = 4'd15;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_START  = 3'd0,
    REG_WINDOW_LENGTH = 3'd1,
    REG_LINE_WIDTH    = 3'd2,
    REG_BLACK_LEVEL   = 3'd3,
    REG_WHITE_LEVEL   = 3'd4
  } cfg_reg_e;

  // Field close sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_NQ_LO,
    ST_NQ_HI,
    ST_SS,
    ST_RN,
    ST_X,
    ST_CAP,
    ST_CAPCHK,
    ST_NORM,
    ST_SQ_ISSUE,
    ST_SQ_TAKE,
    ST_SCALE,
    ST_ROUND,
    ST_EMIT
  } state_e;

  // Window statistics handed from the accumulator to the sequencer.
  typedef struct packed {
    logic [CNT_W-1:0]        count;
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         square_sum;
  } win_stat_t;

endpackage

// ===== rtl/blpm_stream_if.sv =====
interface blpm_in_if;
  import blpm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic [POS_W-1:0]         position;
  logic                     field_end;
  logic                     frame_end;

  modport source (output valid, sample, position, field_end, frame_end, input ready);
  modport sink (input valid, sample, position, field_end, frame_end, output ready);
endinterface

interface blpm_out_if;
  import blpm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [PSNR_W-1:0] psnr_db;
  logic [FUSED_W-1:0]       fields_used;

  modport source (output valid, psnr_db, fields_used, input ready);
  modport sink (input valid, psnr_db, fields_used, output ready);
endinterface

// ===== rtl/blpm_mul_unit.sv =====
module blpm_mul_unit (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_q;

  // Shared 32x32 multiplier; the product is registered for the next step.
  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_q;

endmodule

// ===== rtl/blpm_window_acc.sv =====
module blpm_window_acc #(
  parameter int SAMPLE_WIDTH = blpm_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              beat_i,
  input  logic signed [blpm_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [blpm_pkg::POS_W-1:0]        position_i,
  input  logic [blpm_pkg::LEN_W-1:0]        window_start_i,
  input  logic [blpm_pkg::LEN_W-1:0]        window_length_i,
  input  logic                              clear_i,
  output blpm_pkg::win_stat_t               stat_o
);
  import blpm_pkg::*;

  localparam int EXT_SHIFT = SAMPLE_W - SAMPLE_WIDTH;

  logic [CNT_W-1:0]        count_q, count_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [SQ_W-1:0]         sq_q, sq_d;
  logic signed [SAMPLE_W-1:0] shifted;
  logic signed [SAMPLE_W-1:0] sx;
  logic signed [2*SAMPLE_W-1:0] sq_term;
  logic [LEN_W:0]          win_end;
  logic                    in_window;

  // Take the low sample bits as a two's complement value.
  assign shifted = sample_i <<< EXT_SHIFT;
  assign sx      = shifted >>> EXT_SHIFT;
  assign sq_term = sx * sx;

  // Window test with the per-field sample limit.
  assign win_end   = {1'b0, window_start_i} + {1'b0, window_length_i};
  assign in_window = (position_i >= window_start_i) &&
                     ({1'b0, position_i} < win_end) &&
                     (count_q < CNT_W'(window_length_i));

  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    sq_d    = sq_q;
    if (clear_i) begin
      count_d = '0;
      sum_d   = '0;
      sq_d    = '0;
    end else if (beat_i && in_window) begin
      count_d = count_q + CNT_W'(1);
      sum_d   = sum_q + SUM_W'(sx);
      sq_d    = sq_q + SQ_W'(unsigned'(sq_term));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      sq_q    <= '0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
      sq_q    <= sq_d;
    end
  end

  assign stat_o.count      = count_q;
  assign stat_o.sum        = sum_q;
  assign stat_o.square_sum = sq_q;

endmodule

// ===== rtl/blpm_field_seq.sv =====
module blpm_field_seq #(
  parameter int MAX_LINE_WIDTH = blpm_pkg::DEF_MAX_LINE_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic                                frame_i,
  input  blpm_pkg::win_stat_t                 stat_i,
  input  logic [blpm_pkg::LEN_W-1:0]          window_start_i,
  input  logic [blpm_pkg::LEN_W-1:0]          window_length_i,
  input  logic [blpm_pkg::LW_W-1:0]           line_width_i,
  input  logic signed [blpm_pkg::LEVEL_W-1:0] black_level_i,
  input  logic signed [blpm_pkg::LEVEL_W-1:0] white_level_i,
  output logic                                idle_o,
  output logic                                acc_clear_o,
  output logic [31:0]                         mul_a_o,
  output logic [31:0]                         mul_b_o,
  input  logic [63:0]                         mul_p_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [blpm_pkg::PSNR_W-1:0]  psnr_db_o,
  output logic [blpm_pkg::FUSED_W-1:0]        fields_used_o
);
  import blpm_pkg::*;

  localparam int LWC_W = LW_W + 1;

  state_e state_q, state_d;
  logic                    frame_q, frame_d;
  logic [63:0]             dv_q, dv_d;
  logic [63:0]             x_q, x_d;
  logic [63:0]             lv_q, lv_d;
  logic [5:0]              e_q, e_d;
  logic [15:0]             frac_q, frac_d;
  logic [3:0]              cnt_q, cnt_d;
  logic                    which_q, which_d;
  logic [21:0]             logx_q, logx_d;
  logic [21:0]             logd_q, logd_d;
  logic                    neg_q, neg_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [1:0]              vf_q, vf_d;
  logic                    out_valid_q, out_valid_d;
  logic signed [PSNR_W-1:0] psnr_q, psnr_d;
  logic [FUSED_W-1:0]      fields_q, fields_d;

  logic [LWC_W-1:0]        lw_eff;
  logic [LWC_W-1:0]        win_end;
  logic                    field_ok;
  logic                    capped;
  logic signed [LEVEL_W:0] level_diff;
  logic [LEVEL_W-1:0]      range_abs;
  logic [SUM_W-1:0]        sum_abs;
  logic signed [22:0]      log_diff;
  logic [21:0]             log_diff_abs;
  logic signed [42:0]      scaled;
  logic signed [42:0]      rounded;
  logic [15:0]             frac_next;
  logic signed [ACC_W:0]   mean_two;
  logic                    out_free;

  // Field validity: nonempty window, inside the line, nonzero signal range.
  assign lw_eff   = (LWC_W'(line_width_i) < LWC_W'(MAX_LINE_WIDTH)) ?
                    LWC_W'(line_width_i) : LWC_W'(MAX_LINE_WIDTH);
  assign win_end  = LWC_W'(window_start_i) + LWC_W'(window_length_i);
  assign field_ok = (stat_i.count != '0) && (win_end <= lw_eff) &&
                    (white_level_i != black_level_i);

  // Operand preparation for the shared multiplier.
  assign level_diff   = (LEVEL_W+1)'(white_level_i) - (LEVEL_W+1)'(black_level_i);
  assign range_abs    = level_diff[LEVEL_W] ? LEVEL_W'(-level_diff) : LEVEL_W'(level_diff);
  assign sum_abs      = stat_i.sum[SUM_W-1] ? SUM_W'(-stat_i.sum) : SUM_W'(stat_i.sum);
  assign log_diff     = $signed({1'b0, logx_q}) - $signed({1'b0, logd_q});
  assign log_diff_abs = log_diff[22] ? 22'(-log_diff) : 22'(log_diff);

  // Noise floor test: D * 10^10 <= X, only possible when D is small.
  assign capped = (dv_q[63:CAP_D_BITS] == '0) &&
                  ((mul_p_i + (dv_q << TEN_POW10_HI_SHIFT)) <= x_q);

  // One bit of the log2 fraction per squaring.
  assign frac_next = {frac_q[14:0], mul_p_i[63]};

  // Rounded field PSNR in Q8.8 from the scaled log difference.
  assign scaled  = neg_q ? -$signed({1'b0, mul_p_i[41:0]}) : $signed({1'b0, mul_p_i[41:0]});
  assign rounded = (scaled + 43'sd8388608) >>> 24;

  assign mean_two = ((ACC_W+1)'(acc_q) + (ACC_W+1)'(1)) >>> 1;
  assign out_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (start_i) state_d = ST_START;
      ST_START: begin
        if (field_ok && (vf_q < 2'd2)) state_d = ST_NQ_LO;
        else state_d = frame_q ? ST_EMIT : ST_IDLE;
      end
      ST_NQ_LO:    state_d = ST_NQ_HI;
      ST_NQ_HI:    state_d = ST_SS;
      ST_SS:       state_d = ST_RN;
      ST_RN:       state_d = ST_X;
      ST_X:        state_d = ST_CAP;
      ST_CAP:      state_d = ST_CAPCHK;
      ST_CAPCHK: begin
        if (capped) state_d = frame_q ? ST_EMIT : ST_IDLE;
        else state_d = ST_NORM;
      end
      ST_NORM:     if (lv_q[63] || (e_q == '0)) state_d = ST_SQ_ISSUE;
      ST_SQ_ISSUE: state_d = ST_SQ_TAKE;
      ST_SQ_TAKE: begin
        if (cnt_q != SQ_LAST) state_d = ST_SQ_ISSUE;
        else if (!which_q) state_d = ST_NORM;
        else state_d = ST_SCALE;
      end
      ST_SCALE:    state_d = ST_ROUND;
      ST_ROUND:    state_d = frame_q ? ST_EMIT : ST_IDLE;
      ST_EMIT:     if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    frame_d     = frame_q;
    dv_d        = dv_q;
    x_d         = x_q;
    lv_d        = lv_q;
    e_d         = e_q;
    frac_d      = frac_q;
    cnt_d       = cnt_q;
    which_d     = which_q;
    logx_d      = logx_q;
    logd_d      = logd_q;
    neg_d       = neg_q;
    acc_d       = acc_q;
    vf_d        = vf_q;
    out_valid_d = out_valid_q;
    psnr_d      = psnr_q;
    fields_d    = fields_q;
    mul_a_o     = '0;
    mul_b_o     = '0;
    acc_clear_o = 1'b0;

    // The result register empties when its beat is taken.
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) frame_d = frame_i;
      end
      ST_START: begin
        if (!(field_ok && (vf_q < 2'd2))) acc_clear_o = 1'b1;
      end
      ST_NQ_LO: begin
        mul_a_o = 32'(stat_i.count);
        mul_b_o = stat_i.square_sum[31:0];
      end
      ST_NQ_HI: begin
        dv_d    = mul_p_i;
        mul_a_o = 32'(stat_i.count);
        mul_b_o = 32'(stat_i.square_sum[SQ_W-1:32]);
      end
      ST_SS: begin
        dv_d    = dv_q + (mul_p_i << 32);
        mul_a_o = 32'(sum_abs);
        mul_b_o = 32'(sum_abs);
      end
      ST_RN: begin
        dv_d    = dv_q - mul_p_i;
        mul_a_o = 32'(range_abs);
        mul_b_o = 32'(stat_i.count);
      end
      ST_X: begin
        acc_clear_o = 1'b1;
        mul_a_o     = mul_p_i[31:0];
        mul_b_o     = mul_p_i[31:0];
      end
      ST_CAP: begin
        x_d     = mul_p_i;
        mul_a_o = dv_q[31:0];
        mul_b_o = TEN_POW10_LO;
      end
      ST_CAPCHK: begin
        if (capped) begin
          acc_d = acc_q + CAP_Q8;
          vf_d  = vf_q + 2'd1;
        end else begin
          lv_d    = x_q;
          e_d     = LOG_INT_MAX;
          frac_d  = '0;
          cnt_d   = '0;
          which_d = 1'b0;
        end
      end
      ST_NORM: begin
        if (!lv_q[63] && (e_q != '0)) begin
          lv_d = lv_q << 1;
          e_d  = e_q - 6'd1;
        end
      end
      ST_SQ_ISSUE: begin
        mul_a_o = lv_q[63:32];
        mul_b_o = lv_q[63:32];
      end
      ST_SQ_TAKE: begin
        frac_d         = frac_next;
        lv_d[63:32]    = mul_p_i[63] ? mul_p_i[63:32] : mul_p_i[62:31];
        cnt_d          = cnt_q + 4'd1;
        if (cnt_q == SQ_LAST) begin
          if (!which_q) begin
            logx_d  = {e_q, frac_next};
            lv_d    = dv_q;
            e_d     = LOG_INT_MAX;
            frac_d  = '0;
            cnt_d   = '0;
            which_d = 1'b1;
          end else begin
            logd_d = {e_q, frac_next};
          end
        end
      end
      ST_SCALE: begin
        neg_d   = log_diff[22];
        mul_a_o = 32'(log_diff_abs);
        mul_b_o = DB_PER_LOG2_Q16;
      end
      ST_ROUND: begin
        acc_d = acc_q + rounded[ACC_W-1:0];
        vf_d  = vf_q + 2'd1;
      end
      ST_EMIT: begin
        if (out_free) begin
          if (vf_q != '0) begin
            out_valid_d = 1'b1;
            psnr_d      = (vf_q == 2'd2) ? mean_two[PSNR_W-1:0] : acc_q[PSNR_W-1:0];
            fields_d    = vf_q;
          end
          acc_d = '0;
          vf_d  = '0;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      frame_q     <= 1'b0;
      acc_q       <= '0;
      vf_q        <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      e_q         <= '0;
      which_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      frame_q     <= frame_d;
      acc_q       <= acc_d;
      vf_q        <= vf_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      e_q         <= e_d;
      which_q     <= which_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    dv_q     <= dv_d;
    x_q      <= x_d;
    lv_q     <= lv_d;
    frac_q   <= frac_d;
    logx_q   <= logx_d;
    logd_q   <= logd_d;
    neg_q    <= neg_d;
    psnr_q   <= psnr_d;
    fields_q <= fields_d;
  end

  assign idle_o        = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign psnr_db_o     = psnr_q;
  assign fields_used_o = fields_q;

  // At most two fields are ever counted into a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni) vf_q != 2'd3)
    else $error("frame field count exceeded two");

  // A new result always reports one or two contributing fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (fields_q == 2'd1 || fields_q == 2'd2))
    else $error("result emitted without a valid field");

  // The log2 normalizer never sees a zero operand.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_NORM |-> lv_q != '0)
    else $error("log2 of zero");

endmodule

// ===== rtl/black_level_psnr_meter.sv =====
// Black-level PSNR meter. Samples of the black test line arrive one beat at a
// time with their position; samples inside the window are counted, summed and
// square-summed in the same cycle, so in-field beats are taken back to back.
// A beat that closes a field or frame holds off the input while one shared
// 32x32 multiplier and a bit-at-a-time log2 normalizer work out the field
// PSNR: the work ends early when the noise cap applies, otherwise it takes two
// normalizations and 32 squarings. The frame result, the mean of the valid
// fields in Q8.8 dB, waits in an output register while the next samples are
// accepted; a frame end that finds it still full holds off the input.
module black_level_psnr_meter #(
  parameter int MAX_LINE_WIDTH = blpm_pkg::DEF_MAX_LINE_WIDTH,
  parameter int SAMPLE_WIDTH   = blpm_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  blpm_in_if.sink                           in_i,
  blpm_out_if.source                        out_o,
  input  logic                              cfg_we_i,
  input  logic [blpm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [blpm_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import blpm_pkg::*;

  logic [LEN_W-1:0]          window_start_q;
  logic [LEN_W-1:0]          window_length_q;
  logic [LW_W-1:0]           line_width_q;
  logic signed [LEVEL_W-1:0] black_level_q;
  logic signed [LEVEL_W-1:0] white_level_q;

  logic        beat;
  logic        close_beat;
  logic        idle;
  logic        acc_clear;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  win_stat_t   stat;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_start_q  <= RST_WINDOW_START;
      window_length_q <= RST_WINDOW_LENGTH;
      line_width_q    <= RST_LINE_WIDTH;
      black_level_q   <= RST_BLACK_LEVEL;
      white_level_q   <= RST_WHITE_LEVEL;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_WINDOW_START:  window_start_q  <= cfg_wdata_i[LEN_W-1:0];
        REG_WINDOW_LENGTH: window_length_q <= cfg_wdata_i[LEN_W-1:0];
        REG_LINE_WIDTH:    line_width_q    <= cfg_wdata_i[LW_W-1:0];
        REG_BLACK_LEVEL:   black_level_q   <= $signed(cfg_wdata_i[LEVEL_W-1:0]);
        REG_WHITE_LEVEL:   white_level_q   <= $signed(cfg_wdata_i[LEVEL_W-1:0]);
        default: ;
      endcase
    end
  end

  // Input handshake.
  assign in_i.ready = idle;
  assign beat       = in_i.valid && idle;
  assign close_beat = beat && (in_i.field_end || in_i.frame_end);

  blpm_window_acc #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_window_acc (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .beat_i          (beat),
    .sample_i        (in_i.sample),
    .position_i      (in_i.position),
    .window_start_i  (window_start_q),
    .window_length_i (window_length_q),
    .clear_i         (acc_clear),
    .stat_o          (stat)
  );

  blpm_mul_unit u_mul_unit (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  blpm_field_seq #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
  ) u_field_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (close_beat),
    .frame_i         (in_i.frame_end),
    .stat_i          (stat),
    .window_start_i  (window_start_q),
    .window_length_i (window_length_q),
    .line_width_i    (line_width_q),
    .black_level_i   (black_level_q),
    .white_level_i   (white_level_q),
    .idle_o          (idle),
    .acc_clear_o     (acc_clear),
    .mul_a_o         (mul_a),
    .mul_b_o         (mul_b),
    .mul_p_i         (mul_p),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .psnr_db_o       (out_o.psnr_db),
    .fields_used_o   (out_o.fields_used)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import blpm_pkg::*;

  // Scoreboard: bit-exact prediction of frame PSNR results from accepted beats.
  class psnr_scoreboard;
    typedef struct {
      logic signed [PSNR_W-1:0] psnr_db;
      logic [FUSED_W-1:0]       fields_used;
    } frame_result_t;

    // Register copies.
    bit [LEN_W-1:0]          win_start;
    bit [LEN_W-1:0]          win_len;
    bit [LW_W-1:0]           line_w;
    bit signed [LEVEL_W-1:0] black;
    bit signed [LEVEL_W-1:0] white;

    // Window and frame state.
    longint          win_sum;
    longint unsigned win_sq_sum;
    int unsigned     win_count;
    longint          frame_acc;
    int unsigned     good_fields;

    frame_result_t pending_frames[$];
    int            errors;

    function new();
      win_start   = RST_WINDOW_START;
      win_len     = RST_WINDOW_LENGTH;
      line_w      = RST_LINE_WIDTH;
      black       = RST_BLACK_LEVEL;
      white       = RST_WHITE_LEVEL;
      win_sum     = 0;
      win_sq_sum  = 0;
      win_count   = 0;
      frame_acc   = 0;
      good_fields = 0;
      errors      = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_WINDOW_START:  win_start = value[LEN_W-1:0];
        REG_WINDOW_LENGTH: win_len = value[LEN_W-1:0];
        REG_LINE_WIDTH:    line_w = value[LW_W-1:0];
        REG_BLACK_LEVEL:   black = value;
        REG_WHITE_LEVEL:   white = value;
        default: ;
      endcase
    endfunction

    // Truncating log2 in unsigned Q16, by repeated squaring of the mantissa.
    function bit [31:0] log2_q16(longint unsigned v);
      int          e;
      logic [127:0] m;
      bit [31:0]   frac;
      e = 63;
      frac = 0;
      while (e > 0 && v[e] == 1'b0) e--;
      if (e >= 31) m = 128'(v) >> (e - 31);
      else m = 128'(v) << (31 - e);
      for (int i = 0; i < 16; i++) begin
        m = (m * m) >> 31;
        frac = frac << 1;
        if (m[127:32] != 0) begin
          frac[0] = 1'b1;
          m = m >> 1;
        end
      end
      return 32'(e) * 32'd65536 + frac;
    endfunction

    function void close_field();
      int              lw_eff;
      int              level_diff;
      longint unsigned rng, n, abs_s, noise, signal;
      longint          diff, field_q8;
      lw_eff = (line_w < 4096) ? int'(line_w) : 4096;
      if (win_count != 0 && int'(win_start) + int'(win_len) <= lw_eff && white != black
          && good_fields < 2) begin
        level_diff = int'(white) - int'(black);
        rng = (level_diff < 0) ? -level_diff : level_diff;
        n = win_count;
        abs_s = (win_sum < 0) ? -win_sum : win_sum;
        noise = n * win_sq_sum - abs_s * abs_s;
        signal = (rng * n) * (rng * n);
        if (noise <= signal / 64'd10000000000) begin
          field_q8 = 20480;
        end else begin
          diff = longint'(log2_q16(signal)) - longint'(log2_q16(noise));
          field_q8 = (diff * 197283 + (longint'(1) <<< 23)) >>> 24;
        end
        frame_acc += field_q8;
        good_fields++;
      end
      win_sum = 0;
      win_sq_sum = 0;
      win_count = 0;
    endfunction

    // Note one accepted input beat.
    function void note_beat(logic signed [SAMPLE_W-1:0] sample, logic [POS_W-1:0] pos,
                            logic fld_end, logic frm_end);
      frame_result_t r;
      longint        mean;
      if (int'(pos) >= int'(win_start) && int'(pos) < int'(win_start) + int'(win_len)
          && win_count < win_len) begin
        win_sum += sample;
        win_sq_sum += longint'(sample) * longint'(sample);
        win_count++;
      end
      if (fld_end || frm_end) close_field();
      if (frm_end) begin
        if (good_fields != 0) begin
          mean = frame_acc;
          if (good_fields == 2) mean = (mean + 1) >>> 1;
          r.psnr_db = mean[15:0];
          r.fields_used = good_fields[1:0];
          pending_frames.insert(pending_frames.size(), r);
        end
        frame_acc = 0;
        good_fields = 0;
      end
    endfunction

    // Check one accepted result beat against the oldest expected frame.
    function void check_result(logic signed [PSNR_W-1:0] psnr, logic [FUSED_W-1:0] used);
      frame_result_t r;
      if (pending_frames.size() == 0) begin
        $error("unexpected result beat: psnr_db=%0d fields_used=%0d", psnr, used);
        errors++;
        return;
      end
      r = pending_frames.pop_front();
      if (psnr !== r.psnr_db) begin
        $error("psnr_db: expected %0d, actual %0d", r.psnr_db, psnr);
        errors++;
      end
      if (used !== r.fields_used) begin
        $error("fields_used: expected %0d, actual %0d", r.fields_used, used);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bit hold_req;
  bit calm;
  int beats_sent;

  psnr_scoreboard sb;

  blpm_in_if  in_ch ();
  blpm_out_if out_ch ();

  black_level_psnr_meter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch.sink),
    .out_o       (out_ch.source),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Clock.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Overall limit.
  initial begin
    #50ms;
    $display("tb_top: done, errors");
    $finish;
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.psnr_db, out_ch.fields_used);
    end
  end

  // Receiver: random stall bursts, a long hold-off on each request.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (3000) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // Send one beat, with an optional random gap before it.
  task automatic send_beat(logic signed [SAMPLE_W-1:0] sample, logic [POS_W-1:0] pos,
                           logic fld_end, logic frm_end);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample    <= sample;
    in_ch.position  <= pos;
    in_ch.field_end <= fld_end;
    in_ch.frame_end <= frm_end;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_beat(sample, pos, fld_end, frm_end);
    beats_sent++;
  endtask

  // Stop sending and wait until every expected frame has come out.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_frames.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  // One register write; the enable is high for a single cycle and drops before the next write.
  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk_i);
  endtask

  task automatic set_window(int ws, int wl, int lw, int blk, int wht);
    drain();
    write_reg(REG_WINDOW_START, 16'(ws));
    write_reg(REG_WINDOW_LENGTH, 16'(wl));
    write_reg(REG_LINE_WIDTH, 16'(lw));
    write_reg(REG_BLACK_LEVEL, 16'(blk));
    write_reg(REG_WHITE_LEVEL, 16'(wht));
  endtask

  // One frame of measured lines around the window, with stray beats mixed in.
  task automatic send_frame(int n_fields);
    int len, start, mode, noise;
    logic fe;
    for (int f = 0; f < n_fields; f++) begin
      len = $urandom_range(1, (sb.win_len > 30) ? 38 : int'(sb.win_len) + 8);
      start = int'(sb.win_start) - int'($urandom_range(0, 4));
      if (start < 0) start = 0;
      mode = $urandom_range(0, 3);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 29) == 0) begin
          send_beat(16'($urandom), 12'($urandom), $urandom_range(0, 9) == 0,
                    $urandom_range(0, 14) == 0);
        end
        case (mode)
          0: noise = 0;
          1: noise = $signed($urandom_range(0, 6)) - 3;
          2: noise = $signed($urandom_range(0, 400)) - 200;
          default: noise = $signed($urandom_range(0, 65535)) - 32768;
        endcase
        fe = (k == len - 1) && (f < n_fields - 1 || $urandom_range(0, 1) == 1);
        send_beat(16'(int'(sb.black) + noise), 12'(start + k), fe,
                  (k == len - 1) && (f == n_fields - 1));
      end
    end
  endtask

  // Stimulus.
  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.sample    <= '0;
    in_ch.position  <= '0;
    in_ch.field_end <= 1'b0;
    in_ch.frame_end <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= '0;
    cfg_wdata       <= '0;
    hold_req = 1'b0;
    calm = 1'b0;
    beats_sent = 0;
    sb = new();
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, extreme samples and positions.
    send_beat(16'sh7FFF, 12'd212, 1'b0, 1'b0);
    send_beat(-16'sh8000, 12'd213, 1'b0, 1'b0);
    send_beat(16'sd256, 12'd4095, 1'b1, 1'b0);
    send_beat(16'sd256, 12'd0, 1'b0, 1'b1);
    send_beat(16'sd0, 12'd500, 1'b0, 1'b1);
    send_beat(16'sd0, 12'd100, 1'b0, 1'b1);

    // Extreme levels, constant black gives the noise cap.
    set_window(0, 8, 4096, -32768, 32767);
    for (int i = 0; i < 3; i++) send_beat(-16'sh8000, 12'(i), 1'b0, 1'b0);
    send_beat(-16'sh8000, 12'd3, 1'b1, 1'b0);
    send_beat(16'sh7FFF, 12'd0, 1'b0, 1'b0);
    send_beat(-16'sh8000, 12'd1, 1'b0, 1'b1);
    // Window at the top of the line, white below black.
    set_window(4088, 7, 4096, 32767, -32768);
    send_beat(16'sh7FFF, 12'd4094, 1'b1, 1'b0);
    send_beat(16'sh7FF0, 12'd4095, 1'b0, 1'b0);
    send_beat(16'sh7FFE, 12'd4090, 1'b0, 1'b1);
    // White equals black, and a window past the line: no results.
    set_window(0, 4, 8191, 100, 100);
    send_beat(16'sd101, 12'd1, 1'b0, 1'b1);
    set_window(10, 20, 25, 0, 700);
    send_beat(16'sd3, 12'd12, 1'b0, 1'b1);
    // Zero-length window: empty fields.
    set_window(4095, 0, 0, 0, 700);
    send_beat(16'sd3, 12'd4095, 1'b0, 1'b1);

    // Random phases.
    while (beats_sent < 2000) begin
      set_window($urandom_range(0, 40), $urandom_range(0, 9) == 0 ? 4095 :
                 $urandom_range(1, 24), $urandom_range(0, 1) ? 4096 :
                 $urandom_range(60, 8191), $signed($urandom_range(0, 65535)) - 32768,
                 $signed($urandom_range(0, 65535)) - 32768);
      if ($urandom_range(0, 4) == 0) write_reg(REG_WHITE_LEVEL, 16'(sb.black + 16'sd1));
      if (beats_sent > 600 && beats_sent < 900) hold_req = 1'b1;
      calm = (beats_sent > 1800);
      for (int fr = 0; fr < 8; fr++) begin
        send_frame($urandom_range(0, 5) == 0 ? $urandom_range(1, 3) : 2);
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/blpm_pkg.sv
rtl/blpm_stream_if.sv
rtl/blpm_mul_unit.sv
rtl/blpm_window_acc.sv
rtl/blpm_field_seq.sv
rtl/black_level_psnr_meter.sv
tb/tb_top.sv
